>>> rtl/bcrcs_pkg.sv
// Package: constants and the byte-wide CRC-16 update for the block CRC sum core.
`timescale 1ns / 1ps

package bcrcs_pkg;

    localparam logic [15:0] CRC_INIT         = 16'h1D0F;
    localparam logic [15:0] CRC_GENERATOR    = 16'h1021;
    localparam logic [7:0]  LENGTH_AT_RESET  = 8'd100;

    typedef enum logic {
        FUNC_DATA = 1'b0,
        FUNC_EOF  = 1'b1
    } func_t;

    // MSB-first CRC-16 update over one byte, unrolled.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_GENERATOR;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/block_crc16_sum_core.sv
// Top level: block CRC-16 sum core with config write channel and registered result.
`timescale 1ns / 1ps

// Usage:
//   s_ channel carries one beat per file byte (s_func = data) or an end-of-file
//   beat (s_func = end of file). Data bytes are cut into blocks of block_length
//   bytes; each block gets a CRC-16 (poly 0x1021, init 0x1D0F) and is added into
//   a 32-bit wrapping sum. An end-of-file beat closes the partial block and
//   returns the sum as one m_ beat; the file state then clears.
//   cfg_ channel writes block_length (0 acts as 1); cfg_ready is always high.
//   Write it only while the core is idle.
// Throughput: one input beat per cycle while s_ready is high; the CRC update, block
//   close and sum add are combinational, ahead of the state and result registers.
// Result: the sum is on m_ in the cycle after the end-of-file beat is taken.
// Stall: the result register holds while m_ready is low; s_ready stays high
//   as long as the result register is empty or being drained this cycle.
// Reset: aresetn low at a clock edge clears the file state, sets block_length
//   to 100 and empties the result register. No clearing pass is needed.
module block_crc16_sum_core
    import bcrcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_checksum_sum
);

    logic [7:0]  block_length_reg;
    logic [15:0] block_crc_reg, block_crc_next;
    logic [7:0]  block_count_reg, block_count_next;
    logic        zero_seen_reg, zero_seen_next;
    logic [31:0] running_sum_reg, running_sum_next;
    logic        m_valid_reg;
    logic [31:0] m_sum_reg, m_sum_next;

    logic        s_accept;
    logic        is_eof;
    logic [7:0]  limit;
    logic [8:0]  count_inc;
    logic        block_full;
    logic [15:0] crc_after;
    logic        zero_after;
    logic [15:0] crc_close_data;
    logic [15:0] crc_close_eof;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign is_eof    = (func_t'(s_func) == FUNC_EOF);
    assign m_valid   = m_valid_reg;
    assign m_checksum_sum = m_sum_reg;

    assign limit      = (block_length_reg == 8'd0) ? 8'd1 : block_length_reg;
    assign count_inc  = {1'b0, block_count_reg} + 9'd1;
    assign block_full = (count_inc >= {1'b0, limit});

    always_comb begin
        crc_after      = zero_seen_reg ? block_crc_reg : crc_feed(block_crc_reg, s_data_byte);
        zero_after     = zero_seen_reg || (s_data_byte == 8'd0);
        crc_close_data = zero_after ? crc_after : crc_feed(crc_after, 8'd0);
        crc_close_eof  = zero_seen_reg ? block_crc_reg : crc_feed(block_crc_reg, 8'd0);

        block_crc_next   = block_crc_reg;
        block_count_next = block_count_reg;
        zero_seen_next   = zero_seen_reg;
        running_sum_next = running_sum_reg;
        m_sum_next       = running_sum_reg + {16'd0, crc_close_eof};

        if (is_eof) begin
            block_crc_next   = CRC_INIT;
            block_count_next = 8'd0;
            zero_seen_next   = 1'b0;
            running_sum_next = 32'd0;
        end else if (block_full) begin
            block_crc_next   = CRC_INIT;
            block_count_next = 8'd0;
            zero_seen_next   = 1'b0;
            running_sum_next = running_sum_reg + {16'd0, crc_close_data};
        end else begin
            block_crc_next   = crc_after;
            block_count_next = count_inc[7:0];
            zero_seen_next   = zero_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_length_reg <= LENGTH_AT_RESET;
            block_crc_reg    <= CRC_INIT;
            block_count_reg  <= 8'd0;
            zero_seen_reg    <= 1'b0;
            running_sum_reg  <= 32'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                block_length_reg <= cfg_data;
            end
            if (s_accept) begin
                block_crc_reg   <= block_crc_next;
                block_count_reg <= block_count_next;
                zero_seen_reg   <= zero_seen_next;
                running_sum_reg <= running_sum_next;
            end
            if (s_accept && is_eof) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && is_eof) begin
            m_sum_reg <= m_sum_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_eof_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && is_eof |=> m_valid_reg)
        else $error("end-of-file beat did not load the result register");

    a_result_from_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s_accept && is_eof))
        else $error("result appeared without an end-of-file beat");

    a_eof_clears_file: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && is_eof |=> (block_crc_reg == CRC_INIT) && (block_count_reg == 8'd0)
            && !zero_seen_reg && (running_sum_reg == 32'd0))
        else $error("file state not cleared after end of file");

    a_count_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !is_eof |=> ({1'b0, block_count_reg} < {1'b0, $past(limit)}))
        else $error("block count reached the block length without closing");
`endif

endmodule

>>> tb/block_crc16_sum_core_tb.sv
// Testbench: block CRC-16 sum core, directed table plus randomized files checked by a predictor.
`timescale 1ns / 1ps

module block_crc16_sum_core_tb;
    import bcrcs_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam logic [31:0] EMPTY_BLOCK_SUM = 32'h0000_CC9C;
    localparam logic [31:0] FOUR_EMPTY_SUM  = 32'h0003_3270;
    localparam int          PHASES          = 7;

    typedef enum logic { ROW_BEAT, ROW_CFG } row_kind_t;
    typedef enum { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

    typedef struct {
        row_kind_t   kind;
        func_t       func;
        logic [7:0]  value;
        bit          typed;
        logic [31:0] sum;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_checksum_sum;

    logic [7:0]  model_len;
    logic [15:0] open_crc;
    logic [7:0]  open_count;
    bit          open_zero;
    logic [31:0] file_sum;

    logic [31:0] expected_sums [$];
    int          src_idle;
    int          snk_stall;
    int          errors;
    int          beats_taken;
    int          sums_seen;
    int          cfg_writes;
    int unsigned cycle_count;

    // value is the block length on a register row, the file byte otherwise
    row_t plan [0:27] = '{
        '{ROW_BEAT, FUNC_EOF,  8'h00, 1'b1, EMPTY_BLOCK_SUM},
        '{ROW_BEAT, FUNC_EOF,  8'hFF, 1'b1, EMPTY_BLOCK_SUM},
        '{ROW_CFG,  FUNC_DATA, 8'd1,  1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'h00, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'h00, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'h00, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_EOF,  8'h00, 1'b1, FOUR_EMPTY_SUM},
        '{ROW_BEAT, FUNC_DATA, 8'hFF, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'h80, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'h01, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_EOF,  8'h55, 1'b0, 32'h0},
        '{ROW_CFG,  FUNC_DATA, 8'd0,  1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'hA5, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'h5A, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_EOF,  8'h00, 1'b0, 32'h0},
        '{ROW_CFG,  FUNC_DATA, 8'd255, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'h31, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'h00, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'h77, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_EOF,  8'hAA, 1'b0, 32'h0},
        '{ROW_CFG,  FUNC_DATA, 8'd5,  1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'h12, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'h34, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'h56, 1'b0, 32'h0},
        '{ROW_CFG,  FUNC_DATA, 8'd2,  1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'h78, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_DATA, 8'h9A, 1'b0, 32'h0},
        '{ROW_BEAT, FUNC_EOF,  8'h00, 1'b0, 32'h0}
    };

    int phase_len   [0:PHASES-1] = '{1, 255, 0, 7, 2, 100, 0};
    int phase_items [0:PHASES-1] = '{100, 300, 80, 120, 100, 150, 100};
    int phase_odds  [0:PHASES-1] = '{12, 400, 12, 16, 12, 60, 20};

    block_crc16_sum_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_checksum_sum (m_checksum_sum)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run exceeded %0d cycles with %0d sums pending", CYCLE_LIMIT,
                   expected_sums.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= snk_stall);
    end

    always @(negedge aclk) begin : sum_check
        logic [31:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_sums.size() == 0) begin
                $error("checksum_sum: expected nothing, actual %08h", m_checksum_sum);
                errors++;
            end else begin
                want = expected_sums.pop_front();
                if (m_checksum_sum !== want) begin
                    $error("checksum_sum: expected %08h, actual %08h", want, m_checksum_sum);
                    errors++;
                end
                sums_seen++;
            end
        end
    end

    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_GENERATOR;
            end
        end
        return r;
    endfunction

    function void close_block();
        logic [15:0] c;
        c = open_zero ? open_crc : crc16_byte(open_crc, 8'h00);
        file_sum   = file_sum + {16'h0000, c};
        open_crc   = CRC_INIT;
        open_count = 8'd0;
        open_zero  = 1'b0;
    endfunction

    task automatic predict_beat(input func_t f, input logic [7:0] b, output bit has_sum,
                                output logic [31:0] sum_out);
        logic [8:0] limit;
        logic [8:0] n;
        has_sum = 1'b0;
        sum_out = '0;
        limit   = (model_len == 8'd0) ? 9'd1 : {1'b0, model_len};
        if (f == FUNC_EOF) begin
            close_block();
            has_sum  = 1'b1;
            sum_out  = file_sum;
            file_sum = '0;
        end else begin
            if (!open_zero) begin
                open_crc = crc16_byte(open_crc, b);
                if (b == 8'h00) begin
                    open_zero = 1'b1;
                end
            end
            n = {1'b0, open_count} + 9'd1;
            if (n >= limit) begin
                close_block();
            end else begin
                open_count = n[7:0];
            end
        end
    endtask

    task automatic send_beat(input func_t f, input logic [7:0] b, input bit typed,
                             input logic [31:0] typed_sum);
        bit          ok;
        bit          has_sum;
        logic [31:0] predicted;
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= f;
        s_data_byte <= b;
        do begin
            @(negedge aclk);
            ok = s_ready;
            @(posedge aclk);
        end while (!ok);
        predict_beat(f, b, has_sum, predicted);
        if (has_sum) begin
            expected_sums.push_back(typed ? typed_sum : predicted);
        end
        beats_taken++;
    endtask

    task automatic write_length(input logic [7:0] len);
        bit ok;
        s_valid <= 1'b0;
        while (expected_sums.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do begin
            @(negedge aclk);
            ok = cfg_ready;
            @(posedge aclk);
        end while (!ok);
        cfg_valid <= 1'b0;
        model_len  = len;
        cfg_writes++;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                src_idle  = 0;
                snk_stall = 0;
            end
            IDLE_SENDER: begin
                src_idle  = 49;
                snk_stall = 0;
            end
            IDLE_RECEIVER: begin
                src_idle  = 0;
                snk_stall = 49;
            end
            default: begin
                src_idle  = 7;
                snk_stall = 7;
            end
        endcase
    endtask

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 2) begin
            return 8'h00;
        end else if (r == 2) begin
            return 8'hFF;
        end else if (r == 3) begin
            return 8'h01 << $urandom_range(0, 7);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        func_t      f;
        logic [7:0] len;
        errors      = 0;
        beats_taken = 0;
        sums_seen   = 0;
        cfg_writes  = 0;
        cycle_count = 0;
        set_idle(IDLE_NONE);
        model_len   = LENGTH_AT_RESET;
        open_crc    = CRC_INIT;
        open_count  = 8'd0;
        open_zero   = 1'b0;
        file_sum    = '0;
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= 8'd0;
        s_valid     <= 1'b0;
        s_func      <= FUNC_DATA;
        s_data_byte <= 8'd0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < $size(plan); i++) begin
            if (plan[i].kind == ROW_CFG) begin
                write_length(plan[i].value);
            end else begin
                send_beat(plan[i].func, plan[i].value, plan[i].typed, plan[i].sum);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            len = (p == PHASES - 1) ? 8'($urandom_range(1, 254)) : 8'(phase_len[p]);
            write_length(len);
            set_idle(idle_mode_t'(p % 4));
            for (int k = 0; k < phase_items[p]; k++) begin
                f = ($urandom_range(1, phase_odds[p]) == 1) ? FUNC_EOF : FUNC_DATA;
                send_beat(f, pick_byte(), 1'b0, 32'h0);
            end
        end

        s_valid <= 1'b0;
        while (expected_sums.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        $display("Took %0d input beats over %0d block length writes (0, 1, 2 and 255 among them)",
                 beats_taken, cfg_writes);
        $display("Compared %0d end-of-file sums under four sender and receiver idle patterns",
                 sums_seen);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
